@@ src/pps_pkg.sv @@
// Package for the preemptive priority scheduler.
// Holds sizes, the waiting-entry type, the store write request type and the ranking function.
// No dependencies.
package pps_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  prio;
		logic [15:0] left;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} wr_req_t;

	// True when a is served before b: higher priority, then lower id, then less time left.
	function automatic logic ranks_above(entry_t a, entry_t b);
		logic [39:0] ra;
		logic [39:0] rb;
		ra = {a.prio, ~a.id, ~a.left};
		rb = {b.prio, ~b.id, ~b.left};
		return ra > rb;
	endfunction

endpackage

@@ src/pps_store.sv @@
// Waiting-job store of the scheduler: one write port, one registered read port.
// Depends on pps_pkg.
module pps_store (
	input  logic                       clk,
	input  pps_pkg::wr_req_t           wr,
	input  logic [pps_pkg::IDX_W-1:0]  rd_addr,
	output pps_pkg::entry_t            rd_data
);

	pps_pkg::entry_t mem [pps_pkg::QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

@@ src/preemptive_priority_scheduler.sv @@
// Top level of the preemptive priority scheduler.
// Depends on pps_pkg and pps_store.
//
// Jobs arrive as input transactions in arrival order. Before an arrival is taken
// in, every job finishing at or before it is retired and one output transaction
// is sent per completion; tlast marks the final completion caused by an input.
// The block takes one input at a time. For every retired job that has waiting
// successors it makes one pass over the waiting store, in which a single
// comparator scans the store one entry per cycle to find the next job. A marked
// last input drains all jobs.
module preemptive_priority_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // job_id[15:0], arrival_time[47:16], run_time[63:48], priority_req[71:64]
	input  logic        s_tlast,  // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // done_id[15:0], finish_time[47:16]
	output logic        m_tlast,  // last_of_run
	output logic        m_tuser   // overflow_seen
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_CHECK  = 8'b0000_0010,
		ST_ARRIVE = 8'b0000_0100,
		ST_DRAIN  = 8'b0000_1000,
		ST_SCAN   = 8'b0001_0000,
		ST_TAIL   = 8'b0010_0000,
		ST_MOVE   = 8'b0100_0000,
		ST_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [15:0] in_id_q;
	logic [31:0] in_arr_q;
	logic [15:0] in_rt_q;
	logic [7:0]  in_pr_q;
	logic        in_last_q;

	logic        run_v_q;
	logic [15:0] run_id_q;
	logic [7:0]  run_pr_q;
	logic [15:0] run_left_q;
	logic [31:0] run_start_q;
	logic        sfi_q;
	logic [pps_pkg::CNT_W-1:0] count_q;
	logic        dropped_q;
	logic        drain_q;

	logic [pps_pkg::IDX_W-1:0] scan_i_q;
	logic        rd_v_s1;
	logic [pps_pkg::IDX_W-1:0] rd_idx_s1;
	logic        best_v_q;
	logic [pps_pkg::IDX_W-1:0] best_idx_q;
	pps_pkg::entry_t best_q;
	pps_pkg::entry_t last_q;
	logic [31:0] at_q;

	logic        pend_v_q;
	logic [15:0] pend_id_q;
	logic [31:0] pend_fin_q;

	logic        out_v_q;
	logic [15:0] out_id_q;
	logic [31:0] out_fin_q;
	logic        out_last_q;
	logic        out_ovf_q;

	pps_pkg::wr_req_t wr;
	logic [pps_pkg::IDX_W-1:0] rd_addr;
	pps_pkg::entry_t rd_data;

	pps_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	logic [32:0] fin_sum;
	logic [31:0] fin;
	logic [31:0] t_eff;
	logic [31:0] elapsed;
	logic [15:0] rem;
	logic        win;
	logic        full;
	logic        out_free;
	logic        can_prod;
	logic        take;
	logic        out_load;

	always_comb begin
		fin_sum  = {1'b0, run_start_q} + {17'd0, run_left_q};
		fin      = fin_sum[32] ? 32'hFFFF_FFFF : fin_sum[31:0];
		t_eff    = (in_arr_q > run_start_q) ? in_arr_q : run_start_q;
		elapsed  = t_eff - run_start_q;
		rem      = run_left_q - elapsed[15:0];
		win      = (in_pr_q > run_pr_q) ||
			(sfi_q && (run_start_q == t_eff) && (in_pr_q == run_pr_q) && (in_id_q < run_id_q));
		full     = (count_q >= pps_pkg::CNT_W'(pps_pkg::QUEUE_DEPTH));
		out_free = !out_v_q || m_tready;
		can_prod = !pend_v_q || out_free;
		take     = !best_v_q || pps_pkg::ranks_above(rd_data, best_q);
		rd_addr  = (state_q == ST_SCAN) ? scan_i_q : best_idx_q;
		// The output register is loaded when a held completion moves out.
		out_load = (((state_q == ST_CHECK) || (state_q == ST_DRAIN)) && run_v_q &&
			((state_q == ST_DRAIN) || (fin <= in_arr_q)) && can_prod && pend_v_q) ||
			((state_q == ST_FINISH) && pend_v_q && out_free);
	end

	// Store writes: parking an entry on arrival, or moving the last entry into the freed slot.
	always_comb begin
		wr.en   = 1'b0;
		wr.addr = count_q[pps_pkg::IDX_W-1:0];
		wr.data = '{id: in_id_q, prio: in_pr_q, left: in_rt_q};
		unique case (state_q)
			ST_ARRIVE: begin
				if (run_v_q && !full) begin
					wr.en = 1'b1;
					if (win) begin
						wr.data = '{id: run_id_q, prio: run_pr_q, left: rem};
					end
				end
			end
			ST_MOVE: begin
				wr.en   = 1'b1;
				wr.addr = best_idx_q;
				wr.data = last_q;
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_fin_q, out_id_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			rd_idx_s1 <= scan_i_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_v_q     <= 1'b0;
			run_id_q    <= '0;
			run_pr_q    <= '0;
			run_left_q  <= '0;
			run_start_q <= '0;
			sfi_q       <= 1'b0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			drain_q     <= 1'b0;
			scan_i_q    <= '0;
			rd_v_s1     <= 1'b0;
			best_v_q    <= 1'b0;
			best_idx_q  <= '0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
			in_id_q     <= '0;
			in_arr_q    <= '0;
			in_rt_q     <= '0;
			in_pr_q     <= '0;
			in_last_q   <= 1'b0;
			best_q      <= '0;
			last_q      <= '0;
			at_q        <= '0;
			pend_id_q   <= '0;
			pend_fin_q  <= '0;
			out_id_q    <= '0;
			out_fin_q   <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			rd_v_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						in_id_q   <= s_tdata[15:0];
						in_arr_q  <= s_tdata[47:16];
						in_rt_q   <= s_tdata[63:48];
						in_pr_q   <= s_tdata[71:64];
						in_last_q <= s_tlast;
						drain_q   <= 1'b0;
						state_q   <= ST_CHECK;
					end
				end
				ST_CHECK, ST_DRAIN: begin
					if (run_v_q && (state_q == ST_DRAIN || fin <= in_arr_q)) begin
						// Retire the running job; the held completion moves to the output.
						if (can_prod) begin
							if (pend_v_q) begin
								out_id_q   <= pend_id_q;
								out_fin_q  <= pend_fin_q;
								out_last_q <= 1'b0;
								out_ovf_q  <= dropped_q;
							end
							pend_v_q   <= 1'b1;
							pend_id_q  <= run_id_q;
							pend_fin_q <= fin;
							at_q       <= fin;
							if (count_q == '0) begin
								run_v_q <= 1'b0;
								sfi_q   <= 1'b0;
							end else begin
								scan_i_q <= '0;
								best_v_q <= 1'b0;
								state_q  <= ST_SCAN;
							end
						end
					end else if (state_q == ST_CHECK) begin
						state_q <= ST_ARRIVE;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_ARRIVE: begin
					if (!run_v_q) begin
						run_v_q     <= 1'b1;
						run_id_q    <= in_id_q;
						run_pr_q    <= in_pr_q;
						run_left_q  <= in_rt_q;
						run_start_q <= in_arr_q;
						sfi_q       <= 1'b1;
					end else if (full) begin
						dropped_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
						if (win) begin
							run_id_q    <= in_id_q;
							run_pr_q    <= in_pr_q;
							run_left_q  <= in_rt_q;
							run_start_q <= t_eff;
							sfi_q       <= 1'b1;
						end
					end
					drain_q <= in_last_q;
					state_q <= in_last_q ? ST_DRAIN : ST_FINISH;
				end
				ST_SCAN: begin
					if (rd_v_s1 && take) begin
						best_v_q   <= 1'b1;
						best_q     <= rd_data;
						best_idx_q <= rd_idx_s1;
					end
					if ({1'b0, scan_i_q} == pps_pkg::CNT_W'(count_q - 1'b1)) begin
						state_q <= ST_TAIL;
					end else begin
						scan_i_q <= scan_i_q + 1'b1;
					end
				end
				ST_TAIL: begin
					// The last store entry arrives now; it refills the slot of the chosen job.
					last_q <= rd_data;
					if (take) begin
						best_v_q   <= 1'b1;
						best_q     <= rd_data;
						best_idx_q <= rd_idx_s1;
					end
					state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					count_q     <= count_q - 1'b1;
					run_v_q     <= 1'b1;
					run_id_q    <= best_q.id;
					run_pr_q    <= best_q.prio;
					run_left_q  <= best_q.left;
					run_start_q <= at_q;
					sfi_q       <= 1'b0;
					state_q     <= drain_q ? ST_DRAIN : ST_CHECK;
				end
				ST_FINISH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_id_q   <= pend_id_q;
						out_fin_q  <= pend_fin_q;
						out_last_q <= 1'b1;
						out_ovf_q  <= dropped_q;
						pend_v_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sim/tb_preemptive_priority_scheduler.sv @@
// Self-checking testbench for the preemptive priority scheduler.
// Depends on pps_pkg and the scheduler RTL. A directed table runs first, then random runs of jobs,
// then a burst that fills the waiting store. Completions are compared with a local predictor.
module tb_preemptive_priority_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [15:0] id;
		logic [31:0] arr;
		logic [15:0] rt;
		logic [7:0]  pr;
		logic        last;
	} job_t;

	typedef struct {
		logic [15:0] id;
		logic [31:0] fin;
		logic        last;
		logic        ovf;
	} completion_t;

	typedef struct {
		job_t        job;
		logic        typed;
		logic [15:0] exp_id;
		logic [31:0] exp_fin;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	completion_t completions_due[$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          idling_on;
	bit          hold_req;
	bit          all_sent;

	// Scheduler state mirrored by the predictor.
	logic                run_valid;
	logic [15:0]         run_id;
	logic [7:0]          run_prio;
	logic [15:0]         run_left;
	logic [31:0]         run_start;
	logic                run_from_idle;
	pps_pkg::entry_t     waiting[pps_pkg::QUEUE_DEPTH];
	int                  wait_count;
	logic                dropped;

	preemptive_priority_scheduler uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [31:0] running_finish();
		logic [32:0] f;
		f = {1'b0, run_start} + {17'b0, run_left};
		return f[32] ? 32'hFFFF_FFFF : f[31:0];
	endfunction

	function automatic logic [39:0] rank(pps_pkg::entry_t e);
		return {e.prio, ~e.id, ~e.left};
	endfunction

	function automatic void retire_running(ref completion_t out[$]);
		completion_t c;
		int best;
		c.id = run_id;
		c.fin = running_finish();
		c.last = 1'b0;
		c.ovf = 1'b0;
		out.push_back(c);
		if (wait_count == 0) begin
			run_valid = 1'b0;
			run_from_idle = 1'b0;
			return;
		end
		best = 0;
		for (int i = 1; i < wait_count; i++)
			if (rank(waiting[i]) > rank(waiting[best])) best = i;
		run_valid = 1'b1;
		run_id = waiting[best].id;
		run_prio = waiting[best].prio;
		run_left = waiting[best].left;
		run_start = c.fin;
		run_from_idle = 1'b0;
		wait_count--;
		waiting[best] = waiting[wait_count];
	endfunction

	function automatic void park(logic [15:0] id, logic [7:0] pr, logic [15:0] left);
		waiting[wait_count].id = id;
		waiting[wait_count].prio = pr;
		waiting[wait_count].left = left;
		wait_count++;
	endfunction

	// Applies one arrival and returns the completions it causes.
	function automatic void schedule_job(job_t j, ref completion_t out[$]);
		logic [31:0] t;
		logic [31:0] elapsed;
		logic        win;
		out.delete();
		while (run_valid && running_finish() <= j.arr) retire_running(out);
		if (!run_valid) begin
			run_valid = 1'b1;
			run_id = j.id;
			run_prio = j.pr;
			run_left = j.rt;
			run_start = j.arr;
			run_from_idle = 1'b1;
		end else begin
			t = (j.arr > run_start) ? j.arr : run_start;
			win = (j.pr > run_prio) || (run_from_idle && run_start == t &&
				j.pr == run_prio && j.id < run_id);
			if (wait_count >= pps_pkg::QUEUE_DEPTH) begin
				dropped = 1'b1;
			end else if (win) begin
				elapsed = t - run_start;
				park(run_id, run_prio, run_left - elapsed[15:0]);
				run_id = j.id;
				run_prio = j.pr;
				run_left = j.rt;
				run_start = t;
				run_from_idle = 1'b1;
			end else begin
				park(j.id, j.pr, j.rt);
			end
		end
		if (j.last)
			while (run_valid) retire_running(out);
		foreach (out[k]) out[k].ovf = dropped;
		if (out.size() > 0) out[out.size()-1].last = 1'b1;
	endfunction

	task automatic send_job(job_t j, output completion_t out[$]);
		if (idling_on && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {j.pr, j.rt, j.arr, j.id};
		s_tlast <= j.last;
		do @(posedge clk); while (!s_tready);
		schedule_job(j, out);
		foreach (out[k]) completions_due.push_back(out[k]);
	endtask

	// Receiver side with random stalls and one long hold-off.
	initial begin
		int hold;
		bit hold_used;
		hold = 0;
		hold_used = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_used) begin
				hold = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(idling_on && $urandom_range(99) < 7);
			end
		end
	end

	always @(posedge clk) begin
		completion_t want;
		if (m_tvalid && m_tready) begin
			if (completions_due.size() == 0) begin
				report("unexpected completion id", {16'b0, m_tdata[15:0]}, 32'b0);
			end else begin
				want = completions_due.pop_front();
				if (m_tdata[15:0] !== want.id) report("done_id", {16'b0, m_tdata[15:0]}, {16'b0, want.id});
				if (m_tdata[47:16] !== want.fin) report("finish_time", m_tdata[47:16], want.fin);
				if (m_tlast !== want.last) report("last_of_run", {31'b0, m_tlast}, {31'b0, want.last});
				if (m_tuser !== want.ovf) report("overflow_seen", {31'b0, m_tuser}, {31'b0, want.ovf});
			end
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	row_t directed[] = '{
		'{'{16'd5, 32'd0, 16'd10, 8'd3, 1'b1}, 1'b1, 16'd5, 32'd10},
		'{'{16'hFFFF, 32'hFFFF_FFF0, 16'hFFFF, 8'hFF, 1'b1}, 1'b1, 16'hFFFF, 32'hFFFF_FFFF},
		'{'{16'd1, 32'd1000, 16'd50, 8'd1, 1'b0}, 1'b0, 16'd0, 32'd0},
		'{'{16'd2, 32'd1010, 16'd20, 8'd9, 1'b0}, 1'b0, 16'd0, 32'd0},
		'{'{16'd3, 32'd1010, 16'd5, 8'd9, 1'b0}, 1'b0, 16'd0, 32'd0},
		'{'{16'd4, 32'd1100, 16'd1, 8'd0, 1'b1}, 1'b0, 16'd0, 32'd0},
		'{'{16'd9, 32'd2000, 16'd30, 8'd4, 1'b0}, 1'b0, 16'd0, 32'd0},
		'{'{16'd7, 32'd2000, 16'd30, 8'd4, 1'b0}, 1'b0, 16'd0, 32'd0},
		'{'{16'd8, 32'd2000, 16'd30, 8'd4, 1'b1}, 1'b0, 16'd0, 32'd0},
		'{'{16'd20, 32'd3000, 16'd40, 8'd2, 1'b0}, 1'b0, 16'd0, 32'd0},
		'{'{16'd21, 32'd2990, 16'd10, 8'd5, 1'b1}, 1'b0, 16'd0, 32'd0},
		'{'{16'd0, 32'd0, 16'd1, 8'd0, 1'b1}, 1'b1, 16'd0, 32'd1}
	};

	initial begin
		completion_t out[$];
		job_t        j;
		int          sent;
		int          run_len;
		logic [31:0] step;
		idling_on = 1'b1;
		hold_req = 1'b0;
		all_sent = 1'b0;
		run_valid = 1'b0;
		run_id = '0;
		run_prio = '0;
		run_left = '0;
		run_start = '0;
		run_from_idle = 1'b0;
		wait_count = 0;
		dropped = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r]) begin
			send_job(directed[r].job, out);
			if (directed[r].typed) begin
				if (out.size() != 1 || out[0].id !== directed[r].exp_id)
					report("table done_id", {16'b0, out[0].id}, {16'b0, directed[r].exp_id});
				else if (out[0].fin !== directed[r].exp_fin)
					report("table finish_time", out[0].fin, directed[r].exp_fin);
			end
		end

		// Random runs, each closed by a marked last job.
		sent = 0;
		j.arr = '0;
		while (sent < 150) begin
			run_len = $urandom_range(1, 18);
			if ($urandom_range(3) != 0) j.arr = $urandom;
			for (int k = 0; k < run_len; k++) begin
				step = $urandom_range(0, 30);
				if ($urandom_range(19) == 0) j.arr = j.arr - step;
				else if (j.arr <= 32'hFFFF_FFFF - step) j.arr = j.arr + step;
				j.id = ($urandom_range(9) < 7) ? 16'($urandom_range(0, 31)) : 16'($urandom);
				j.rt = ($urandom_range(9) < 8) ? 16'($urandom_range(1, 60)) :
					16'($urandom_range(1, 65535));
				j.pr = ($urandom_range(9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
				j.last = (k == run_len - 1);
				send_job(j, out);
				sent++;
				idling_on = !(sent >= 40 && sent < 90);
				if (sent == 100) hold_req = 1'b1;
				if (sent == 101) hold_req = 1'b0;
			end
		end

		// Equal jobs at one tick fill the waiting store; the later ones are dropped.
		for (int k = 0; k < 20; k++) begin
			j.id = 16'(100 + k);
			j.arr = 32'd50000;
			j.rt = 16'd1000;
			j.pr = 8'd1;
			j.last = (k == 19);
			send_job(j, out);
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		all_sent = 1'b1;
	end

	initial begin
		wait (all_sent);
		while (completions_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/pps_pkg.sv
src/pps_store.sv
src/preemptive_priority_scheduler.sv
sim/tb_preemptive_priority_scheduler.sv
